/* hw/rtl/icsum_pkg.sv */
package icsum_pkg;

  localparam int unsigned HdrBytes  = 20;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [7:0]  ProtoUdp  = 8'd17;
  localparam logic [7:0]  ProtoTcp  = 8'd6;

  // Header byte offsets of interest
  localparam logic [15:0] IdxLenHi  = 16'd2;
  localparam logic [15:0] IdxLenLo  = 16'd3;
  localparam logic [15:0] IdxProto  = 16'd9;
  localparam logic [15:0] IdxSumBeg = 16'd12;
  localparam logic [15:0] UdpCkAt   = 16'(HdrBytes + 6);
  localparam logic [15:0] TcpCkAt   = 16'(HdrBytes + 16);

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_UDP  = 2'd1,
    KIND_TCP  = 2'd2
  } kind_e;

  // One classified byte handed from the front to the back
  typedef struct packed {
    logic [7:0]  data;     // byte value, zero inside the transport checksum field
    logic        add_en;   // byte takes part in the running sum
    logic        low_half; // byte completes a 16-bit word
    logic        last;     // final byte of the packet
    kind_e       kind;     // packet class, meaningful on last only
    logic        pad_en;   // odd byte count: pad the held high byte
    logic [7:0]  proto;    // protocol number, meaningful on last only
    logic [15:0] len_term; // total length minus header, meaningful on last only
  } icsum_op_t;

endpackage

/* hw/rtl/icsum_front.sv */
module icsum_front
  import icsum_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = 65535
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_i,
  output icsum_op_t  op_o
);

  logic [15:0] byte_index_q, byte_index_d;
  logic [7:0]  proto_q, proto_d;
  logic [15:0] total_len_q, total_len_d;

  logic        counted;
  logic        in_ck_field;
  logic [16:0] end_cnt;

  always_comb begin
    counted      = byte_index_q < 16'(MAX_PACKET_BYTES);
    proto_d      = proto_q;
    total_len_d  = total_len_q;
    byte_index_d = byte_index_q;

    if (counted) begin
      if (byte_index_q == IdxLenHi) begin
        total_len_d[15:8] = data_byte_i;
      end else if (byte_index_q == IdxLenLo) begin
        total_len_d[7:0] = data_byte_i;
      end else if (byte_index_q == IdxProto) begin
        proto_d = data_byte_i;
      end
      byte_index_d = byte_index_q + 16'd1;
    end

    in_ck_field = ((proto_q == ProtoUdp) &&
                   (byte_index_q == UdpCkAt || byte_index_q == UdpCkAt + 16'd1)) ||
                  ((proto_q == ProtoTcp) &&
                   (byte_index_q == TcpCkAt || byte_index_q == TcpCkAt + 16'd1));

    end_cnt = counted ? ({1'b0, byte_index_q} + 17'd1) : 17'(MAX_PACKET_BYTES);

    op_o.data     = in_ck_field ? 8'd0 : data_byte_i;
    op_o.add_en   = counted && (byte_index_q >= IdxSumBeg);
    op_o.low_half = byte_index_q[0];
    op_o.last     = last_i;
    op_o.pad_en   = end_cnt[0];
    op_o.proto    = proto_d;
    op_o.len_term = total_len_d - 16'(HdrBytes);

    if (end_cnt < 17'(HdrBytes)) begin
      op_o.kind = KIND_NONE;
    end else if (proto_d == ProtoUdp) begin
      op_o.kind = KIND_UDP;
    end else if (proto_d == ProtoTcp) begin
      op_o.kind = KIND_TCP;
    end else begin
      op_o.kind = KIND_NONE;
    end
  end

  // Restart the packet state after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q <= '0;
      proto_q      <= '0;
      total_len_q  <= '0;
    end else if (accept_i) begin
      if (last_i) begin
        byte_index_q <= '0;
        proto_q      <= '0;
        total_len_q  <= '0;
      end else begin
        byte_index_q <= byte_index_d;
        proto_q      <= proto_d;
        total_len_q  <= total_len_d;
      end
    end
  end

endmodule

/* hw/rtl/icsum_fifo.sv */
module icsum_fifo
  import icsum_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  icsum_op_t push_data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output icsum_op_t pop_data_o
);

  icsum_op_t             mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0]   count_q;

  assign full_o     = count_q == FifoCntW'(FifoDepth);
  assign empty_o    = count_q == '0;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/icsum_back.sv */
module icsum_back
  import icsum_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        op_valid_i,
  input  icsum_op_t   op_i,
  output logic        op_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] checksum_o,
  output logic [1:0]  kind_o
);

  // Accumulator
  logic [31:0] sum_q, sum_d;
  logic [7:0]  held_q, held_d;

  // Stage 1: packet sum and pseudo-header tail
  logic        s1_valid_q;
  logic [31:0] s1_sum_q;
  logic [17:0] s1_tail_q, tail_d;
  kind_e       s1_kind_q;

  // Stage 2: first fold
  logic        s2_valid_q;
  logic [16:0] s2_fold_q;
  logic [31:0] total;
  kind_e       s2_kind_q;

  // Output register
  logic        out_valid_q;
  logic [15:0] out_ck_q;
  kind_e       out_kind_q;
  logic [15:0] fold2;

  logic out_ready, adv2, s2_ready, adv1, s1_ready;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign adv2      = s2_valid_q && out_ready;
  assign s2_ready  = !s2_valid_q || adv2;
  assign adv1      = s1_valid_q && s2_ready;
  assign s1_ready  = !s1_valid_q || adv1;
  assign op_pop_o  = op_valid_i && (!op_i.last || s1_ready);

  always_comb begin
    held_d = held_q;
    sum_d  = sum_q;
    if (op_i.add_en) begin
      if (op_i.low_half) begin
        sum_d = sum_q + {16'd0, held_q, op_i.data};
      end else begin
        held_d = op_i.data;
      end
    end
    tail_d = (op_i.pad_en ? {2'b00, held_d, 8'd0} : 18'd0)
           + {10'd0, op_i.proto} + {2'b00, op_i.len_term};
    total  = s1_sum_q + {14'd0, s1_tail_q};
    fold2  = s2_fold_q[15:0] + {15'd0, s2_fold_q[16]};
  end

  // Accumulate; restart after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      held_q <= '0;
    end else if (op_pop_o) begin
      if (op_i.last) begin
        sum_q  <= '0;
        held_q <= '0;
      end else begin
        sum_q  <= sum_d;
        held_q <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= op_pop_o && op_i.last;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_ready) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_pop_o && op_i.last) begin
      s1_sum_q  <= sum_d;
      s1_tail_q <= tail_d;
      s1_kind_q <= op_i.kind;
    end
    if (adv1) begin
      s2_fold_q <= {1'b0, total[15:0]} + {1'b0, total[31:16]};
      s2_kind_q <= s1_kind_q;
    end
    if (adv2) begin
      out_ck_q   <= (s2_kind_q == KIND_NONE) ? 16'd0 : ~fold2;
      out_kind_q <= s2_kind_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign checksum_o  = out_ck_q;
  assign kind_o      = out_kind_q;

endmodule

/* hw/rtl/ipv4_l4_checksum_stream_unit.sv */
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_stall_o | data_byte_i[7:0], last_i
// out     | output    | out_valid_o / out_stall_i | checksum_o[15:0], kind_o[1:0]
//
// One byte is accepted per cycle whenever the byte queue has room; the rate
// is set by the single 32-bit add of the accumulator in the back end.
// Once a packet's last byte leaves the queue, its result is registered in stage 1,
// then stage 2, then the output register; an output stall can hold it in each.
// Reset is asynchronous and active low; it clears all counters and valid flags.
// A stall on the output fills the result pipeline, then the byte queue, and
// only then raises in_stall_o.
module ipv4_l4_checksum_stream_unit
  import icsum_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = 65535
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] checksum_o,
  output logic [1:0]  kind_o
);

  icsum_op_t front_op;
  icsum_op_t back_op;
  logic      fifo_full;
  logic      fifo_empty;
  logic      in_accept;
  logic      back_pop;

  // Take a transaction whenever the queue has a free slot
  assign in_stall_o = fifo_full;
  assign in_accept  = in_valid_i && !fifo_full;

  // Front end: track header fields, mask the transport checksum field,
  // and classify the packet on its last byte
  icsum_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .data_byte_i (data_byte_i),
    .last_i      (last_i),
    .op_o        (front_op)
  );

  // Short queue decouples byte intake from the summing back end
  icsum_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept),
    .push_data_i (front_op),
    .full_o      (fifo_full),
    .pop_i       (back_pop),
    .empty_o     (fifo_empty),
    .pop_data_o  (back_op)
  );

  // Back end: accumulate 16-bit words, add the pseudo-header, fold, invert
  icsum_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (!fifo_empty),
    .op_i        (back_op),
    .op_pop_o    (back_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .checksum_o  (checksum_o),
    .kind_o      (kind_o)
  );

endmodule

/* test/ipv4_l4_checksum_stream_unit_tb.sv */
`timescale 1ns / 1ps

// Byte-stream testbench for the IPv4 transport checksum unit.
// An initial block builds whole packets into a queue of pending byte transactions.
// A clocked driver feeds that queue to the input channel, with random idle cycles.
// A clocked monitor stalls the output channel at random.
// Each result is compared, field by field, with the oldest predicted result.
module ipv4_l4_checksum_stream_unit_tb;
  import icsum_pkg::*;

  localparam int          ClkPeriod      = 12;
  localparam int          ResetCycles    = 7;
  localparam int unsigned MaxPktBytes    = 65535;
  localparam int unsigned SumFromByte    = 12;
  localparam int unsigned UdpCsumByte    = HdrBytes + 6;
  localparam int unsigned TcpCsumByte    = HdrBytes + 16;
  localparam int unsigned RandBytes      = 1050;
  localparam int unsigned RandPackets    = 30;
  localparam int unsigned IdlePercent    = 19;
  localparam int unsigned QuietFrom      = 300;
  localparam int unsigned QuietTo        = 700;
  localparam int          TailCycles     = 40;
  localparam int          RunLimitCycles = 1_000_000;
  localparam int unsigned MaxReports     = 10;

  typedef enum int {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES
  } fill_e;

  // One byte transaction of the input channel
  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         drain_first; // hold this byte until every pending result is back
  } byte_xact_t;

  typedef struct {
    logic [15:0] checksum;
    kind_e       kind;
  } l4_result_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        last_i      = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] checksum_o;
  logic [1:0]  kind_o;

  byte_xact_t  pending_q[$];
  l4_result_t  csum_expect_q[$];
  int unsigned bytes_queued   = 0;
  int unsigned bytes_accepted = 0;
  int unsigned pkts_queued    = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // Predictor state: position in the packet and what the header has told so far
  int unsigned pkt_pos   = 0;
  logic [7:0]  pkt_proto = 8'h00;
  logic [15:0] pkt_len   = 16'h0000;
  logic [31:0] pkt_sum   = 32'h0;
  logic [7:0]  pkt_hi    = 8'h00;

  ipv4_l4_checksum_stream_unit #(
    .MAX_PACKET_BYTES(MaxPktBytes)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .data_byte_i(data_byte_i),
    .last_i     (last_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .checksum_o (checksum_o),
    .kind_o     (kind_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Roll for an idle cycle; none at all inside the quiet window.
  function automatic bit roll_idle();
    if (cycle_count >= QuietFrom && cycle_count < QuietTo) return 1'b0;
    return $urandom_range(99) < IdlePercent;
  endfunction

  // The transport checksum field reads as zero, at fixed offsets per protocol.
  function automatic bit in_csum_field(int unsigned idx);
    if (pkt_proto == ProtoUdp) return idx == UdpCsumByte || idx == UdpCsumByte + 1;
    if (pkt_proto == ProtoTcp) return idx == TcpCsumByte || idx == TcpCsumByte + 1;
    return 1'b0;
  endfunction

  // Fold one accepted byte into the running pseudo-header sum; on the last
  // byte, queue the expected checksum and kind, then clear for the next packet.
  function automatic void accumulate_l4_byte(logic [7:0] b, logic is_last);
    int unsigned idx;
    int unsigned end_cnt;
    bit          counted;
    logic [7:0]  v;
    logic [31:0] acc;
    l4_result_t  res;

    idx     = pkt_pos;
    counted = idx < MaxPktBytes;
    if (counted) begin
      case (idx)
        2: pkt_len[15:8] = b;
        3: pkt_len[7:0]  = b;
        9: pkt_proto     = b;
        default: ;
      endcase
      if (idx >= SumFromByte) begin
        v = in_csum_field(idx) ? 8'h00 : b;
        if (idx[0] == 1'b0) pkt_hi = v;
        else pkt_sum += {16'h0000, pkt_hi, v};
      end
      pkt_pos = idx + 1;
    end
    if (!is_last) return;

    // Bytes past the size limit are dropped, so the count saturates there
    end_cnt      = counted ? idx + 1 : MaxPktBytes;
    res.kind     = KIND_NONE;
    res.checksum = 16'h0000;
    if (end_cnt >= HdrBytes) begin
      if (pkt_proto == ProtoUdp) res.kind = KIND_UDP;
      else if (pkt_proto == ProtoTcp) res.kind = KIND_TCP;
    end
    if (res.kind != KIND_NONE) begin
      acc = pkt_sum;
      // Pad an odd tail with a zero low byte
      if (end_cnt[0]) acc += {16'h0000, pkt_hi, 8'h00};
      acc += {24'h000000, pkt_proto};
      // Length term wraps modulo 2^16 when the header claims less than 20 bytes
      acc += {16'h0000, pkt_len - 16'(HdrBytes)};
      while (acc[31:16] != 16'h0000) acc = {16'h0000, acc[15:0]} + {16'h0000, acc[31:16]};
      // A folded sum of all ones gives zero; it is not turned into all ones
      res.checksum = ~acc[15:0];
    end
    csum_expect_q.push_back(res);

    pkt_pos   = 0;
    pkt_proto = 8'h00;
    pkt_len   = 16'h0000;
    pkt_sum   = 32'h0;
    pkt_hi    = 8'h00;
  endfunction

  function automatic void note_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= MaxReports) $display("[%0t] %s", $realtime, what);
  endfunction

  // Append one packet: the length field at bytes 2..3, the protocol at byte 9,
  // the rest from the chosen fill.
  task automatic queue_packet(int unsigned n_bytes, logic [7:0] proto,
                              logic [15:0] len_field, fill_e fill, bit drain);
    byte_xact_t x;

    for (int unsigned i = 0; i < n_bytes; i++) begin
      case (fill)
        FILL_ZERO: x.data = 8'h00;
        FILL_ONES: x.data = 8'hFF;
        default:   x.data = 8'($urandom_range(255));
      endcase
      if (i == 2) x.data = len_field[15:8];
      if (i == 3) x.data = len_field[7:0];
      if (i == 9) x.data = proto;
      x.last        = (i == n_bytes - 1);
      x.drain_first = drain && (i == 0);
      pending_q.push_back(x);
    end
    bytes_queued += n_bytes;
    pkts_queued++;
  endtask

  // Input driver. Count and predict the transaction that the edge accepts,
  // then load the next byte or idle. Hold the payload while stalled.
  always @(posedge clk_i) begin : drive_bytes
    byte_xact_t x;

    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        accumulate_l4_byte(data_byte_i, last_i);
        bytes_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        // Stay idle on a drain mark until every outstanding result has come
        if (pending_q.size() != 0 && !roll_idle() &&
            !(pending_q[0].drain_first && csum_expect_q.size() != 0)) begin
          x = pending_q.pop_front();
          in_valid_i  <= 1'b1;
          data_byte_i <= x.data;
          last_i      <= x.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor. Compare each accepted result with the oldest prediction,
  // then roll the stall for the next cycle.
  always @(posedge clk_i) begin : check_results
    l4_result_t exp_res;

    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (csum_expect_q.size() == 0) begin
          note_mismatch($sformatf("result with none expected: checksum %04h kind %0d",
                                  checksum_o, kind_o));
        end else begin
          exp_res = csum_expect_q.pop_front();
          if (checksum_o !== exp_res.checksum)
            note_mismatch($sformatf("checksum: expected %04h, got %04h",
                                    exp_res.checksum, checksum_o));
          if (kind_o !== exp_res.kind)
            note_mismatch($sformatf("kind: expected %0d, got %0d", exp_res.kind, kind_o));
        end
      end
      out_stall_i <= roll_idle();
    end
  end

  initial begin : stimulus
    int unsigned roll;
    int unsigned n;
    logic [7:0]  proto;
    bit          drain;

    // Directed packets
    queue_packet(1, ProtoUdp, 16'd1, FILL_RANDOM, 1'b0);        // lone last byte
    queue_packet(19, ProtoUdp, 16'd19, FILL_RANDOM, 1'b0);      // one byte short of a header
    queue_packet(20, ProtoUdp, 16'd20, FILL_RANDOM, 1'b0);      // header only
    queue_packet(27, ProtoUdp, 16'd27, FILL_RANDOM, 1'b0);      // cut inside the UDP csum field
    queue_packet(28, ProtoUdp, 16'd28, FILL_RANDOM, 1'b0);
    queue_packet(40, ProtoTcp, 16'd40, FILL_RANDOM, 1'b0);
    queue_packet(41, ProtoTcp, 16'd41, FILL_RANDOM, 1'b0);      // odd tail
    queue_packet(30, 8'd1, 16'd30, FILL_RANDOM, 1'b0);          // neither UDP nor TCP
    queue_packet(33, ProtoUdp, 16'hFFFF, FILL_ONES, 1'b0);      // all bytes high but the protocol
    queue_packet(24, ProtoTcp, 16'h0000, FILL_RANDOM, 1'b0);    // length below header
    // Zero bytes with length field 2: 17 + 0xFFEE folds to all ones
    queue_packet(28, ProtoUdp, 16'd2, FILL_ZERO, 1'b0);

    // Random packets, mostly well formed, the rest noise
    while (bytes_queued < RandBytes || pkts_queued < RandPackets) begin
      roll  = $urandom_range(99);
      n     = $urandom_range(64, 20);
      proto = $urandom_range(1) ? ProtoUdp : ProtoTcp;
      drain = (pkts_queued == 25) || (pkts_queued == 50);
      if (roll < 70)
        queue_packet(n, proto, 16'(n), FILL_RANDOM, drain);
      else if (roll < 80)
        queue_packet(n, 8'($urandom_range(255)), 16'(n), FILL_RANDOM, drain);
      else if (roll < 90)
        queue_packet($urandom_range(19, 1), proto, 16'($urandom), FILL_RANDOM, drain);
      else
        queue_packet(n, proto, 16'($urandom), FILL_RANDOM, drain);
    end

    // Drain everything, then short packets to see the state cleared
    queue_packet(20, ProtoUdp, 16'd20, FILL_RANDOM, 1'b1);
    queue_packet(45, ProtoTcp, 16'd45, FILL_RANDOM, 1'b0);

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every byte to be taken and every result to be back
    do @(posedge clk_i);
    while (bytes_accepted != bytes_queued || csum_expect_q.size() != 0);
    repeat (TailCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #(RunLimitCycles * ClkPeriod);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/icsum_pkg.sv
hw/rtl/icsum_front.sv
hw/rtl/icsum_fifo.sv
hw/rtl/icsum_back.sv
hw/rtl/ipv4_l4_checksum_stream_unit.sv
test/ipv4_l4_checksum_stream_unit_tb.sv
